### hw/rtl/iirl_pkg.sv
package iirl_pkg;

    // Built-in capacity of the list (1 to 64).
    localparam int CAPACITY = 16;

    // Field widths of one request word and one result word.
    localparam int ACT_W   = 3;
    localparam int POS_W   = 8;
    localparam int VAL_W   = 32;
    localparam int OUT_CNT_W = 7;

    localparam int IN_BITS  = ACT_W + POS_W + VAL_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 1 + VAL_W + OUT_CNT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Entry count holds 0 to CAPACITY; cell index holds 0 to CAPACITY-1.
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT   = 3'd0,
        ACT_REMOVE   = 3'd1,
        ACT_READ     = 3'd2,
        ACT_APPEND   = 3'd3,
        ACT_DROP_END = 3'd4
    } t_action;

    // Decoded command for one request, applied by the cell array.
    typedef struct packed {
        logic             ok;
        logic             shift_up;
        logic             shift_down;
        logic             rd;
        logic [POS_W-1:0] idx;
        logic [CNT_W-1:0] count_next;
    } t_cmd;

endpackage

### hw/rtl/iirl_decode.sv
module iirl_decode (
    input  logic [iirl_pkg::ACT_W-1:0] i_action,
    input  logic [iirl_pkg::POS_W-1:0] i_position,
    input  logic [iirl_pkg::CNT_W-1:0] i_count,
    output iirl_pkg::t_cmd             o_cmd
);
    import iirl_pkg::*;

    logic [POS_W-1:0] count_pos;
    logic             not_full;
    logic             not_empty;

    assign count_pos = POS_W'(i_count);
    assign not_full  = (i_count < CNT_W'(CAPACITY));
    assign not_empty = (i_count != '0);

    always_comb begin
        o_cmd            = '0;
        o_cmd.idx        = i_position;
        o_cmd.count_next = i_count;
        unique case (i_action)
            ACT_INSERT: begin
                o_cmd.ok       = not_full && (i_position <= count_pos);
                o_cmd.shift_up = 1'b1;
            end
            ACT_APPEND: begin
                o_cmd.ok       = not_full;
                o_cmd.shift_up = 1'b1;
                o_cmd.idx      = count_pos;
            end
            ACT_REMOVE: begin
                o_cmd.ok         = (i_position < count_pos);
                o_cmd.shift_down = 1'b1;
            end
            ACT_DROP_END: begin
                o_cmd.ok         = not_empty;
                o_cmd.shift_down = 1'b1;
                o_cmd.idx        = count_pos - POS_W'(1);
            end
            ACT_READ: begin
                o_cmd.ok = (i_position < count_pos);
                o_cmd.rd = 1'b1;
            end
            default: begin
                o_cmd.ok = 1'b0;
            end
        endcase
        if (o_cmd.ok && o_cmd.shift_up) begin
            o_cmd.count_next = i_count + CNT_W'(1);
        end else if (o_cmd.ok && o_cmd.shift_down) begin
            o_cmd.count_next = i_count - CNT_W'(1);
        end
    end

endmodule

### hw/rtl/iirl_cells.sv
module iirl_cells (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  iirl_pkg::t_cmd              i_cmd,
    input  logic [iirl_pkg::VAL_W-1:0]  i_value,
    output logic [iirl_pkg::VAL_W-1:0]  o_read_value
);
    import iirl_pkg::*;

    logic [VAL_W-1:0] r_cell [CAPACITY];
    logic             write_en;

    assign write_en = i_en && i_cmd.ok;

    // Each cell looks only at its own place against the index and takes
    // its lower neighbor on insert or its upper neighbor on remove.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        localparam logic [POS_W-1:0] C_POS = POS_W'(i);
        logic [VAL_W-1:0] n_cell;

        always_comb begin
            n_cell = r_cell[i];
            if (i_cmd.shift_up) begin
                if (C_POS == i_cmd.idx) begin
                    n_cell = i_value;
                end else if (C_POS > i_cmd.idx) begin
                    n_cell = r_cell[(i > 0) ? i - 1 : 0];
                end
            end else if (i_cmd.shift_down) begin
                if ((C_POS >= i_cmd.idx) && (i < CAPACITY - 1)) begin
                    n_cell = r_cell[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (write_en) begin
                r_cell[i] <= n_cell;
            end
        end
    end

    // A successful read always has idx below the count, so the low bits suffice.
    assign o_read_value = (i_cmd.rd && i_cmd.ok) ? r_cell[i_cmd.idx[IDX_W-1:0]] : '0;

endmodule

### hw/rtl/indexed_insert_remove_list.sv
// Channel   Direction  Word fields (lowest bit first)
// s_axis    in         action[2:0], position[10:3], value[42:11], zero fill to 48 bits
// m_axis    out        ok[0], read_value[32:1], count_now[39:33]
//
// One word is taken per cycle while s_axis tready is high. A request word is
// registered, decoded against the entry count and applied to the cell row once the
// result register is free or being emptied, and its result word is registered at
// that same edge. Each cell compares its own place with the index and shifts or
// holds, which keeps the path to one compare and a neighbor select.
// Reset clears the count and both valid flags; list contents are not cleared.
// A stalled output holds the result register; one more request may wait in the
// input register, after which s_axis tready drops.
module indexed_insert_remove_list (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // action, position, value, zero fill
    input  logic [iirl_pkg::IN_W-1:0]    i_s_axis_tdata,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // ok, read_value, count_now
    output logic [iirl_pkg::OUT_W-1:0]   o_m_axis_tdata
);
    import iirl_pkg::*;

    // Input register.
    logic             r_in_valid;
    logic [ACT_W-1:0] r_action;
    logic [POS_W-1:0] r_position;
    logic [VAL_W-1:0] r_value;

    // Result register and list length.
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic [CNT_W-1:0] r_count;

    logic             in_take;
    logic             proceed;
    t_cmd             cmd;
    logic [VAL_W-1:0] read_value;
    logic [OUT_W-1:0] n_out_data;

    // The held request moves on when the result register is free or being emptied.
    assign proceed         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || proceed;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    iirl_decode u_decode (
        .i_action   (r_action),
        .i_position (r_position),
        .i_count    (r_count),
        .o_cmd      (cmd)
    );

    iirl_cells u_cells (
        .i_clk        (i_clk),
        .i_en         (proceed),
        .i_cmd        (cmd),
        .i_value      (r_value),
        .o_read_value (read_value)
    );

    assign n_out_data = OUT_W'({OUT_CNT_W'(cmd.count_next), read_value, cmd.ok});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (proceed) begin
                r_in_valid <= 1'b0;
            end
            if (proceed) begin
                r_out_valid <= 1'b1;
                r_count     <= cmd.count_next;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_action   <= i_s_axis_tdata[ACT_W-1:0];
            r_position <= i_s_axis_tdata[ACT_W +: POS_W];
            r_value    <= i_s_axis_tdata[ACT_W + POS_W +: VAL_W];
        end
        if (proceed) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // The length never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // A refused request leaves the length alone.
    a_fail_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proceed && !cmd.ok |=> r_count == $past(r_count))
        else $error("failed request changed the count");

    // A successful insert or append grows the list by exactly one.
    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proceed && cmd.ok && cmd.shift_up |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not grow the count by one");

    // Only a successful read reports a nonzero value.
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proceed && !(cmd.rd && cmd.ok) |=> r_out_data[1 +: VAL_W] == '0)
        else $error("read value set for a non-read result");

endmodule

### tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import iirl_pkg::*;

    // One expected or observed result word, split into its fields.
    typedef struct packed {
        logic                 ok;
        logic [VAL_W-1:0]     read_value;
        logic [OUT_CNT_W-1:0] count_now;
    } t_list_result;

    // One request waiting to be driven. When hold_for_drain is set, the sender
    // waits until every outstanding result has come back before offering it.
    typedef struct {
        logic [ACT_W-1:0] action;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value;
        bit               hold_for_drain;
    } t_list_request;

    localparam int RANDOM_REQUESTS = 1700;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int DRAIN_CYCLES = 10;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [IN_W-1:0]  s_data = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [OUT_W-1:0] m_data;

    indexed_insert_remove_list dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        // action, position, value, zero fill
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        // ok, read_value, count_now
        .o_m_axis_tdata  (m_data)
    );

    always #4 i_clk = ~i_clk;

    // Requests still to be driven, and results the block still owes us.
    t_list_request request_fifo[$];
    t_list_result  pending_results[$];

    // Shadow of the list contents, updated once per accepted request word.
    logic [VAL_W-1:0] list_cell [CAPACITY];
    int               list_len = 0;

    // Length the generator expects the list to reach, so that most random
    // positions fall inside the list.
    int gen_len = 0;

    int  words_accepted = 0;
    int  quiet_from = 0;
    int  error_count = 0;
    bit  in_fire = 1'b0;
    bit  stim_done = 1'b0;
    int  tx_gap = 0;
    int  rx_gap = 0;
    int  long_hold = 0;
    int  next_hold_at = 400;
    logic quiet;

    // Near the end of the run neither side idles, so the block is also seen
    // streaming at full rate.
    assign quiet = (words_accepted >= quiet_from);

    // Applies one request to the shadow list and returns the result word the
    // block should produce for it. Unused action codes leave the list as it
    // is and report failure with the current count.
    function automatic t_list_result apply_request(input logic [ACT_W-1:0] act,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [VAL_W-1:0] val);
        t_list_result r;
        int           where;
        r = '0;
        case (act)
            ACT_INSERT, ACT_APPEND: begin
                where = (act == ACT_APPEND) ? list_len : int'(pos);
                if (list_len < CAPACITY && where <= list_len) begin
                    for (int i = list_len; i > where; i--) begin
                        list_cell[i] = list_cell[i-1];
                    end
                    list_cell[where] = val;
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            ACT_REMOVE, ACT_DROP_END: begin
                where = (act == ACT_DROP_END) ? list_len - 1 : int'(pos);
                if (where >= 0 && where < list_len) begin
                    for (int i = where; i < list_len - 1; i++) begin
                        list_cell[i] = list_cell[i+1];
                    end
                    list_len--;
                    r.ok = 1'b1;
                end
            end
            ACT_READ: begin
                if (int'(pos) < list_len) begin
                    r.read_value = list_cell[pos[IDX_W-1:0]];
                    r.ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.count_now = OUT_CNT_W'(list_len);
        return r;
    endfunction

    // Queues one request and tracks the list length it will leave behind.
    task automatic add_request(input logic [ACT_W-1:0] act, input int pos,
                               input logic [VAL_W-1:0] val, input bit drain);
        t_list_request q;
        q.action = act;
        q.position = POS_W'(pos);
        q.value = val;
        q.hold_for_drain = drain;
        request_fifo.push_back(q);
        case (act)
            ACT_INSERT: if (gen_len < CAPACITY && q.position <= gen_len) gen_len++;
            ACT_APPEND: if (gen_len < CAPACITY) gen_len++;
            ACT_REMOVE: if (q.position < gen_len) gen_len--;
            ACT_DROP_END: if (gen_len > 0) gen_len--;
            default: begin
            end
        endcase
    endtask

    // Sampling at the rising edge. The result side is checked before the new
    // request is predicted, so a result can never be matched against the
    // expectation of the word accepted at the same edge.
    always @(posedge i_clk) begin
        t_list_result got;
        t_list_result want;
        in_fire <= i_rst_n && s_valid && s_ready;
        if (i_rst_n && m_valid && m_ready) begin
            got = m_data[OUT_BITS-1:0];
            got.ok = m_data[0];
            got.read_value = m_data[VAL_W:1];
            got.count_now = m_data[VAL_W+OUT_CNT_W:VAL_W+1];
            if (pending_results.size() == 0) begin
                $error("result word with no request outstanding: %h", m_data);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.ok !== want.ok) begin
                    $error("ok mismatch: expected %0d, got %0d", want.ok, got.ok);
                    error_count++;
                end
                if (got.read_value !== want.read_value) begin
                    $error("read_value mismatch: expected %h, got %h",
                           want.read_value, got.read_value);
                    error_count++;
                end
                if (got.count_now !== want.count_now) begin
                    $error("count_now mismatch: expected %0d, got %0d",
                           want.count_now, got.count_now);
                    error_count++;
                end
            end
        end
        if (i_rst_n && s_valid && s_ready) begin
            pending_results.push_back(apply_request(s_data[ACT_W-1:0],
                                                    s_data[ACT_W+POS_W-1:ACT_W],
                                                    s_data[IN_BITS-1:ACT_W+POS_W]));
            words_accepted <= words_accepted + 1;
        end
    end

    // Request driver. A word that is offered stays put until the edge that
    // takes it; only then does the driver move on to a gap or the next word.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_fire) begin
            // Still waiting for the block to take the current word.
        end else if (tx_gap != 0) begin
            tx_gap <= tx_gap - 1;
            s_valid <= 1'b0;
        end else if (request_fifo.size() == 0) begin
            s_valid <= 1'b0;
            stim_done <= 1'b1;
        end else if (request_fifo[0].hold_for_drain && pending_results.size() != 0) begin
            // Let the block run completely dry before this word goes out.
            s_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            tx_gap <= $urandom_range(0, 2);
            s_valid <= 1'b0;
        end else begin
            s_valid <= 1'b1;
            s_data <= IN_W'({request_fifo[0].value, request_fifo[0].position,
                             request_fifo[0].action});
            void'(request_fifo.pop_front());
        end
    end

    // Result receiver. Besides short random stalls, it holds off for a long
    // stretch now and then while the sender keeps offering, so that the block
    // fills its internal registers and drops its input ready.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else if (long_hold != 0) begin
            long_hold <= long_hold - 1;
            m_ready <= 1'b0;
        end else if (words_accepted >= next_hold_at) begin
            long_hold <= LONG_HOLD_CYCLES - 1;
            next_hold_at <= next_hold_at + 700;
            m_ready <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap <= rx_gap - 1;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rx_gap <= $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: the slowest correct run is far below this.
    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int               mode;
        int               roll;
        int               pick;
        int               grow_pct;
        int               shrink_pct;
        int               pos;
        logic [ACT_W-1:0] act;
        logic [VAL_W-1:0] val;

        // Empty list: every read, remove and out-of-range insert must fail.
        add_request(ACT_READ, 0, 32'h1234_5678, 1'b0);
        add_request(ACT_REMOVE, 0, 32'h0, 1'b0);
        add_request(ACT_DROP_END, 0, 32'h0, 1'b0);
        add_request(ACT_INSERT, 1, 32'h5555_5555, 1'b0);
        // Insert at the front, append at the end and insert at position equal
        // to the length, with the extreme values.
        add_request(ACT_INSERT, 0, 32'h8000_0000, 1'b0);
        add_request(ACT_APPEND, 255, 32'h7FFF_FFFF, 1'b0);
        add_request(ACT_INSERT, 2, 32'hFFFF_FFFF, 1'b0);
        // Fill the list to capacity.
        while (gen_len < CAPACITY) begin
            add_request(gen_len[0] ? ACT_APPEND : ACT_INSERT, $urandom_range(0, gen_len),
                        $urandom, 1'b0);
        end
        // Full list: insert and append fail, as does an insert far out of range.
        add_request(ACT_INSERT, 0, 32'hAAAA_AAAA, 1'b0);
        add_request(ACT_APPEND, 0, 32'h0000_0001, 1'b0);
        add_request(ACT_INSERT, 255, 32'h0, 1'b0);
        // Reads at the last place, at the length and at the top position.
        add_request(ACT_READ, CAPACITY - 1, 32'h0, 1'b0);
        add_request(ACT_READ, CAPACITY, 32'h0, 1'b0);
        add_request(ACT_READ, 255, 32'h0, 1'b0);
        // Removes at the front, out of range and at the last place.
        add_request(ACT_REMOVE, 0, 32'h0, 1'b0);
        add_request(ACT_REMOVE, 255, 32'h0, 1'b0);
        add_request(ACT_REMOVE, CAPACITY - 2, 32'h0, 1'b0);
        add_request(ACT_DROP_END, 0, 32'h0, 1'b0);
        // Unused action codes are ignored.
        add_request(3'd5, 0, 32'hFFFF_FFFF, 1'b0);
        add_request(3'd6, 1, 32'h0, 1'b0);
        add_request(3'd7, 255, 32'h8000_0000, 1'b0);

        // Random part. The list wanders between empty and full under epochs
        // that favor growing, shrinking or a mix; most positions are legal and
        // a small share of words is pure noise over every code and position.
        mode = 2;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 48 == 0) mode = $urandom_range(0, 2);
            case ($urandom_range(0, 15))
                0: val = 32'h8000_0000;
                1: val = 32'h7FFF_FFFF;
                2: val = 32'h0;
                3: val = 32'hFFFF_FFFF;
                default: val = $urandom;
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                act = ACT_W'($urandom_range(0, 7));
                pos = $urandom_range(0, 255);
            end else begin
                grow_pct = (mode == 0) ? 60 : (mode == 1) ? 15 : 35;
                shrink_pct = (mode == 0) ? 15 : (mode == 1) ? 60 : 35;
                pick = $urandom_range(0, 99);
                if (pick < grow_pct) begin
                    act = $urandom_range(0, 1) ? ACT_INSERT : ACT_APPEND;
                end else if (pick < grow_pct + shrink_pct) begin
                    act = $urandom_range(0, 1) ? ACT_REMOVE : ACT_DROP_END;
                end else begin
                    act = ACT_READ;
                end
                case (act)
                    ACT_INSERT: pos = $urandom_range(0, gen_len);
                    ACT_REMOVE, ACT_READ: pos = (gen_len > 0) ? $urandom_range(0, gen_len - 1) : 0;
                    default: pos = $urandom_range(0, 255);
                endcase
            end
            // Twice in the run the sender waits for the block to drain.
            add_request(act, pos, val, (n == 500) || (n == 1200));
        end

        quiet_from = request_fifo.size() - 250;

        // Synchronous reset, released on a falling edge.
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!stim_done) @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        // Keep watching the result side so that any stray result word is caught.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
